FILE: hdl/xtt_pkg.sv
// Shared types, codes and helpers of the xid translation table.
// No dependencies; xtt_ctrl and the top level refer to this package.
`timescale 1ns / 1ps
`default_nettype none

package xtt_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [2:0] STATUS_DONE           = 3'd0;
    localparam logic [2:0] STATUS_TRANSLATED     = 3'd1;
    localparam logic [2:0] STATUS_NOT_APPLICABLE = 3'd2;
    localparam logic [2:0] STATUS_OWN_NAMESPACE  = 3'd3;
    localparam logic [2:0] STATUS_NOT_FOUND      = 3'd4;
    localparam logic [2:0] STATUS_FULL           = 3'd5;

    localparam logic [1:0] CFG_SHELL_MODE = 2'd0;
    localparam logic [1:0] CFG_PROMOTED   = 2'd1;
    localparam logic [1:0] CFG_WATERMARK  = 2'd2;

    localparam logic [31:0] MIN_NORMAL_XID = 32'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] local_id;
        logic [63:0] global_id;
    } xtt_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [63:0] result_id;
    } xtt_rsp_t;

    typedef struct packed {
        logic        shell_mode;
        logic        promoted;
        logic [31:0] watermark;
    } xtt_cfg_t;

    typedef enum logic [2:0] {
        XS_IDLE,
        XS_SEARCH,
        XS_CHECK,
        XS_SHIFT,
        XS_PLACE,
        XS_RESULT
    } xtt_state_t;

    // true when id a comes after watermark w
    function automatic logic xtt_follows(input logic [31:0] a, input logic [31:0] w);
        logic [31:0] d;
        d = a - w;
        if (w >= MIN_NORMAL_XID) begin
            return (d != 32'd0) && !d[31];
        end
        return a > w;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/xtt_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// Used for the key and value stores; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module xtt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hdl/xtt_ctrl.sv
// Sequencer of the xid translation table: lookup gating, binary search,
// insert shift and clear over the key and value RAMs. Depends on xtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xtt_ctrl #(
    parameter int TABLE_DEPTH = 1024,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire xtt_pkg::xtt_cfg_t cfg,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire xtt_pkg::xtt_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output xtt_pkg::xtt_rsp_t      rsp,
    output logic                   mem_rd_en,
    output logic [AW-1:0]          mem_rd_addr,
    input  wire logic [31:0]       mem_rd_key,
    input  wire logic [63:0]       mem_rd_val,
    output logic                   mem_wr_en,
    output logic [AW-1:0]          mem_wr_addr,
    output logic [31:0]            mem_wr_key,
    output logic [63:0]            mem_wr_val
);

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    xtt_pkg::xtt_state_t state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [31:0]         key_reg, key_next;
    logic [63:0]         gid_reg, gid_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [CW-1:0]       addr_reg, addr_next;
    logic [CW-1:0]       count_reg, count_next;
    xtt_pkg::xtt_rsp_t   rsp_reg, rsp_next;

    logic [CW-1:0] lo_t, hi_t, mid_t;
    logic          hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= xtt_pkg::XS_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        gid_reg  <= gid_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        addr_reg <= addr_next;
        rsp_reg  <= rsp_next;
    end

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        gid_next    = gid_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        addr_next   = addr_reg;
        count_next  = count_reg;
        rsp_next    = rsp_reg;
        req_ready   = 1'b0;
        rsp_valid   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = addr_reg[AW-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = lo_reg[AW-1:0];
        mem_wr_key  = key_reg;
        mem_wr_val  = gid_reg;
        lo_t        = lo_reg;
        hi_t        = hi_reg;
        mid_t       = addr_reg;
        hit         = (lo_reg < count_reg) && (mem_rd_key == key_reg);

        unique case (state_reg)
            xtt_pkg::XS_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    op_next  = req.op;
                    key_next = req.local_id;
                    gid_next = req.global_id;
                    lo_next  = '0;
                    hi_next  = count_reg;
                    rsp_next = '{status: xtt_pkg::STATUS_NOT_APPLICABLE,
                                 found: 1'b0, result_id: 64'd0};
                    state_next = xtt_pkg::XS_RESULT;
                    mid_t = count_reg >> 1;
                    unique case (req.op)
                        xtt_pkg::OP_CLEAR: begin
                            count_next      = '0;
                            rsp_next.status = xtt_pkg::STATUS_DONE;
                        end
                        xtt_pkg::OP_INSERT, xtt_pkg::OP_LOOKUP: begin
                            if (req.op == xtt_pkg::OP_LOOKUP &&
                                (!cfg.shell_mode || req.local_id < xtt_pkg::MIN_NORMAL_XID)) begin
                                rsp_next.status = xtt_pkg::STATUS_NOT_APPLICABLE;
                            end else if (req.op == xtt_pkg::OP_LOOKUP && cfg.promoted &&
                                         cfg.watermark != 32'd0 &&
                                         xtt_pkg::xtt_follows(req.local_id, cfg.watermark)) begin
                                rsp_next.status = xtt_pkg::STATUS_OWN_NAMESPACE;
                            end else if (count_reg != '0) begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = mid_t[AW-1:0];
                                addr_next   = mid_t;
                                state_next  = xtt_pkg::XS_SEARCH;
                            end else begin
                                state_next = xtt_pkg::XS_CHECK;
                            end
                        end
                        default: begin
                            rsp_next.status = xtt_pkg::STATUS_NOT_APPLICABLE;
                        end
                    endcase
                end
            end

            xtt_pkg::XS_SEARCH: begin
                if (mem_rd_key < key_reg) begin
                    lo_t = addr_reg + ONE_C;
                    hi_t = hi_reg;
                end else begin
                    lo_t = lo_reg;
                    hi_t = addr_reg;
                end
                mid_t   = lo_t + ((hi_t - lo_t) >> 1);
                lo_next = lo_t;
                hi_next = hi_t;
                if (lo_t < hi_t) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = mid_t[AW-1:0];
                    addr_next   = mid_t;
                end else begin
                    if (lo_t < count_reg) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = lo_t[AW-1:0];
                    end
                    state_next = xtt_pkg::XS_CHECK;
                end
            end

            xtt_pkg::XS_CHECK: begin
                state_next = xtt_pkg::XS_RESULT;
                if (op_reg == xtt_pkg::OP_LOOKUP) begin
                    rsp_next.status    = hit ? xtt_pkg::STATUS_TRANSLATED
                                             : xtt_pkg::STATUS_NOT_FOUND;
                    rsp_next.found     = hit;
                    rsp_next.result_id = hit ? mem_rd_val : 64'd0;
                end else if (hit) begin
                    mem_wr_en       = 1'b1;
                    rsp_next.status = xtt_pkg::STATUS_DONE;
                end else if (count_reg >= DEPTH_C) begin
                    rsp_next.status = xtt_pkg::STATUS_FULL;
                end else if (lo_reg < count_reg) begin
                    mid_t       = count_reg - ONE_C;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = mid_t[AW-1:0];
                    addr_next   = mid_t;
                    state_next  = xtt_pkg::XS_SHIFT;
                end else begin
                    mem_wr_en       = 1'b1;
                    count_next      = count_reg + ONE_C;
                    rsp_next.status = xtt_pkg::STATUS_DONE;
                end
            end

            xtt_pkg::XS_SHIFT: begin
                mid_t       = addr_reg + ONE_C;
                mem_wr_en   = 1'b1;
                mem_wr_addr = mid_t[AW-1:0];
                mem_wr_key  = mem_rd_key;
                mem_wr_val  = mem_rd_val;
                if (addr_reg == lo_reg) begin
                    state_next = xtt_pkg::XS_PLACE;
                end else begin
                    hi_t        = addr_reg - ONE_C;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = hi_t[AW-1:0];
                    addr_next   = hi_t;
                end
            end

            xtt_pkg::XS_PLACE: begin
                mem_wr_en       = 1'b1;
                count_next      = count_reg + ONE_C;
                rsp_next.status = xtt_pkg::STATUS_DONE;
                state_next      = xtt_pkg::XS_RESULT;
            end

            xtt_pkg::XS_RESULT: begin
                rsp_valid = 1'b1;
                if (rsp_ready) begin
                    state_next = xtt_pkg::XS_IDLE;
                end
            end

            default: begin
                state_next = xtt_pkg::XS_IDLE;
            end
        endcase
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

FILE: hdl/xid_translation_table_top.sv
// Top level of the xid translation table: configuration registers, result
// register, sequencer and key/value RAMs. Depends on xtt_pkg, xtt_ctrl, xtt_ram.
//
// Usage:
//   Requests enter on s_valid/s_ready/s_data (op, local_id, global_id); one
//   result per request leaves on m_valid/m_ready/m_data (status, found,
//   result_id). Registers shell_mode (0), promoted (1) and watermark (2) are
//   written through cfg_wr_en/cfg_index/cfg_wdata; the user must write them
//   only while no request is open, which the block itself does not enforce.
//   One request is in work at a time. A clear, a reserved op, or a lookup
//   stopped by the shell-mode or watermark gate goes straight from acceptance
//   to the result state and from there into the output register. A lookup or
//   insert probes the key RAM at most ceil(log2(n+1)) times for n entries,
//   then passes a check state, where an insert of a known key overwrites it.
//   An insert of a new key also moves every larger entry up by one slot at
//   one entry per cycle, then places the key. The sequencer is free again in
//   the cycle m_valid rises and takes no new request before then.
//   Reset empties the table and clears the configuration registers; the RAMs
//   are not cleared, so no clearing pass is needed. If the receiver stalls, the
//   result waits in the output register while the next request is worked;
//   that one then holds until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module xid_translation_table_top #(
    parameter int TABLE_DEPTH = 1024,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire xtt_pkg::xtt_req_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output xtt_pkg::xtt_rsp_t      m_data
);

    xtt_pkg::xtt_cfg_t cfg_reg, cfg_next;
    logic              m_valid_reg, m_valid_next;
    xtt_pkg::xtt_rsp_t m_data_reg, m_data_next;

    logic              rsp_valid, rsp_ready;
    xtt_pkg::xtt_rsp_t rsp;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   rd_key, wr_key;
    logic [63:0]   rd_val, wr_val;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                xtt_pkg::CFG_SHELL_MODE: cfg_next.shell_mode = cfg_wdata[0];
                xtt_pkg::CFG_PROMOTED:   cfg_next.promoted   = cfg_wdata[0];
                xtt_pkg::CFG_WATERMARK:  cfg_next.watermark  = cfg_wdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    assign rsp_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (rsp_valid && rsp_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = rsp;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    xtt_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .req_valid   (s_valid),
        .req_ready   (s_ready),
        .req         (s_data),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mem_rd_en   (rd_en),
        .mem_rd_addr (rd_addr),
        .mem_rd_key  (rd_key),
        .mem_rd_val  (rd_val),
        .mem_wr_en   (wr_en),
        .mem_wr_addr (wr_addr),
        .mem_wr_key  (wr_key),
        .mem_wr_val  (wr_val)
    );

    xtt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (32)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_key),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_key)
    );

    xtt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (64)
    ) u_val_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_val),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_val)
    );

endmodule

`default_nettype wire
